/* hdl/dvtu_pkg.sv */
package dvtu_pkg;

  localparam int NODE_W         = 6;
  localparam int DIST_W         = 6;
  localparam int NODE_COUNT_W   = 7;
  localparam int NODES_DEF      = 64;

  localparam logic [DIST_W-1:0]       DIST_MAX       = 6'd63;
  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    REQ_LINK = 2'd0,
    REQ_XCHG = 2'd1,
    REQ_READ = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINK,
    ST_XCHG,
    ST_RD_REQ,
    ST_RD_RESP
  } state_t;

  // one table word: route flag, distance, next hop
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] hops;
    logic [NODE_W-1:0] hop;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* hdl/dvtu_table_ram.sv */
module dvtu_table_ram #(
  parameter int AW = 12,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [DW-1:0] rdata0,
  output logic [DW-1:0] rdata1
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

/* hdl/distance_vector_table_update_unit.sv */
// Distance and next-hop table for every ordered node pair, held in one synchronous RAM
// word per pair. After reset the unit sweeps the whole table of 2**AW words (4096 at
// the default of 64 nodes), one word a cycle, and takes no request until the sweep is
// done; node_count writes are taken at any time. After a link request the unit makes
// four table writes through the single write port before it takes the next request.
// An exchange walks destinations 0 to min(node_count, NODES)-1 at one destination a
// cycle, reading sender and receiver words together and writing the receiver word
// back, where the relaxation updates it, in the next cycle; the next request is taken
// once the last write is done. A read result is loaded into the output register from
// the read-response state, and the next request is taken once it is loaded; while the
// result waits there, the unit goes on taking requests, and a further read waits for
// the register to free. Link and exchange requests with a node >= NODES are dropped.
module distance_vector_table_update_unit #(
  parameter int NODES = dvtu_pkg::NODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dvtu_pkg::NODE_COUNT_W-1:0] cfg_wdata,     // node_count
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // node_a, node_b, zero pad
  input  logic [1:0]                        s_axis_tuser,  // req_type
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // hop_distance, next_hop, zero pad
  output logic [0:0]                        m_axis_tuser   // route_known
);

  import dvtu_pkg::*;

  localparam int IDW     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int AW      = 2 * IDW;
  localparam int LIM_MAX = (NODES < 127) ? NODES : 127;
  localparam int CW      = $clog2(LIM_MAX + 1);

  state_t state, state_next;

  logic [NODE_COUNT_W-1:0] node_count;
  logic [AW-1:0]           clr_addr;
  logic [1:0]              link_step;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           limit;
  logic                    p_valid;
  logic [IDW-1:0]          p_dest;
  logic [NODE_W-1:0]       op_a;
  logic [NODE_W-1:0]       op_b;
  logic                    op_ok;

  logic                    out_valid;
  logic                    out_known;
  logic [DIST_W-1:0]       out_dist;
  logic [NODE_W-1:0]       out_hop;
  logic                    out_load;

  logic [NODE_W-1:0] in_a;
  logic [NODE_W-1:0] in_b;
  logic              in_ok;
  logic              accept;
  logic              issue;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr0;
  logic [AW-1:0]     mem_raddr1;
  logic [ENTRY_W-1:0] rd0_raw;
  logic [ENTRY_W-1:0] rd1_raw;
  entry_t            rd0;
  entry_t            rd1;

  logic [DIST_W-1:0] cand;
  logic              upd;

  function automatic logic [AW-1:0] slot_addr(input logic [IDW-1:0] row,
                                               input logic [IDW-1:0] col);
    return {row, col};
  endfunction

  assign in_a   = s_axis_tdata[NODE_W-1:0];
  assign in_b   = s_axis_tdata[2*NODE_W-1:NODE_W];
  assign in_ok  = (32'(in_a) < NODES) && (32'(in_b) < NODES);
  assign accept = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);

  assign limit = (32'(node_count) > NODES) ? CW'(NODES) : CW'(node_count);
  assign issue = (state == ST_XCHG) && (cnt < limit);

  assign rd0 = entry_t'(rd0_raw);
  assign rd1 = entry_t'(rd1_raw);

  // relaxation of the receiver word against the sender word
  always_comb begin
    cand = (rd0.hops == DIST_MAX) ? DIST_MAX : rd0.hops + 6'd1;
    upd  = rd0.valid && (!rd1.valid || (cand < rd1.hops) ||
                         ((cand == rd1.hops) && (op_a < rd1.hop)));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == {AW{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            REQ_LINK: state_next = in_ok ? ST_LINK : ST_IDLE;
            REQ_XCHG: state_next = in_ok ? ST_XCHG : ST_IDLE;
            REQ_READ: state_next = ST_RD_REQ;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_LINK: begin
        if (link_step == 2'd3) begin
          state_next = ST_IDLE;
        end
      end
      ST_XCHG: begin
        if (!issue && !p_valid) begin
          state_next = ST_IDLE;
        end
      end
      ST_RD_REQ:  state_next = ST_RD_RESP;
      ST_RD_RESP: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // table port control
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr0 = slot_addr(IDW'(op_a), IDW'(op_b));
    mem_raddr1 = slot_addr(IDW'(op_b), IDW'(cnt));
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      ST_IDLE: begin
      end
      ST_LINK: begin
        mem_we = 1'b1;
        case (link_step)
          2'd0: begin
            mem_waddr = slot_addr(IDW'(op_a), IDW'(op_b));
            mem_wdata = '{valid: 1'b1, hops: 6'd1, hop: op_b};
          end
          2'd1: begin
            mem_waddr = slot_addr(IDW'(op_b), IDW'(op_a));
            mem_wdata = '{valid: 1'b1, hops: 6'd1, hop: op_a};
          end
          2'd2: begin
            mem_waddr = slot_addr(IDW'(op_a), IDW'(op_a));
            mem_wdata = '{valid: 1'b1, hops: 6'd0, hop: op_a};
          end
          default: begin
            mem_waddr = slot_addr(IDW'(op_b), IDW'(op_b));
            mem_wdata = '{valid: 1'b1, hops: 6'd0, hop: op_b};
          end
        endcase
      end
      ST_XCHG: begin
        mem_re     = issue;
        mem_raddr0 = slot_addr(IDW'(op_a), IDW'(cnt));
        mem_we     = p_valid && upd;
        mem_waddr  = slot_addr(IDW'(op_b), p_dest);
        mem_wdata  = '{valid: 1'b1, hops: cand, hop: op_a};
      end
      ST_RD_REQ: begin
        mem_re = op_ok;
      end
      ST_RD_RESP: begin
        out_load = !out_valid || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      node_count <= NODE_COUNT_RST;
      clr_addr   <= '0;
      link_step  <= '0;
      cnt        <= '0;
      p_valid    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept) begin
        link_step <= '0;
        cnt       <= '0;
        p_valid   <= 1'b0;
      end
      if (state == ST_LINK) begin
        link_step <= link_step + 1'b1;
      end
      if (state == ST_XCHG) begin
        p_valid <= issue;
        if (issue) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_a  <= in_a;
      op_b  <= in_b;
      op_ok <= in_ok;
    end
    if (issue) begin
      p_dest <= IDW'(cnt);
    end
    if (out_load) begin
      out_known <= op_ok && rd0.valid;
      out_dist  <= (op_ok && rd0.valid) ? rd0.hops : '0;
      out_hop   <= (op_ok && rd0.valid) ? rd0.hop : '0;
    end
  end

  dvtu_table_ram #(
    .AW (AW),
    .DW (ENTRY_W)
  ) u_table (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .re     (mem_re),
    .raddr0 (mem_raddr0),
    .raddr1 (mem_raddr1),
    .rdata0 (rd0_raw),
    .rdata1 (rd1_raw)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_hop, out_dist};
  assign m_axis_tuser  = out_known;

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("table written while idle");

  a_xchg_row: assert property (@(posedge clk) disable iff (rst)
    (state == ST_XCHG && mem_we) |-> (mem_waddr[AW-1:IDW] == IDW'(op_b)))
    else $error("exchange wrote outside the receiver row");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_RD_RESP))
    else $error("result raised without a read");

endmodule
